// File: rtl/phss_pkg.sv
// Shared types and constants of the PES header stream sorter.
`timescale 1ns / 1ps
`default_nettype none

package phss_pkg;

  // Default sizes of the PID table and of the stream numbers.
  localparam int PID_COUNT_DEF    = 8192;
  localparam int NUMBER_WIDTH_DEF = 8;

  // Widths of the fixed descriptor fields.
  localparam int PID_W    = 13;
  localparam int BYTE_W   = 8;
  localparam int CODE_W   = 24;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 24;

  // PES header constants.
  localparam logic [CODE_W-1:0] START_CODE   = 24'h000001;
  localparam logic [BYTE_W-1:0] SID_AUDIO_LO = 8'hC0;
  localparam logic [BYTE_W-1:0] SID_AUDIO_HI = 8'hDF;
  localparam logic [BYTE_W-1:0] SID_VIDEO_LO = 8'hE0;
  localparam logic [BYTE_W-1:0] SID_VIDEO_HI = 8'hEF;
  localparam logic [BYTE_W-1:0] HDR_MIN      = 8'd6;
  localparam logic [BYTE_W-1:0] SHORT_LIMIT  = 8'd7;
  localparam logic [BYTE_W-1:0] OPT_MIN_SIZE = 8'd9;
  localparam logic [1:0]        OPT_MARK     = 2'b10;

  // Kind of a registered PID.
  typedef enum logic [1:0] {
    KIND_AUDIO = 2'd0,
    KIND_VIDEO = 2'd1,
    KIND_OTHER = 2'd2
  } es_kind_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_en;
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic out_busy;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// File: rtl/pes_header_stream_sorter.sv
// Top level of the PES header stream sorter.
//
//   Channel   Direction  Fields (lowest bit first)
//   s_axis    in         tdata: pid, payload_size, start_code, stream_id, flag_byte,
//                               header_length; tuser: new_packet
//   m_axis    out        tdata: es_number, data_offset, data_size; tuser: es_type
//
// An accepted descriptor is captured, which reads the PID table, and then looked up,
// which resolves the registered table entry, writes a new PID entry back to the table
// and loads the output register.
// After reset a clearing pass marks every table entry unknown;
// s_axis_tready_o stays low until it ends.
// While a result waits in the output register, the next descriptor is still taken and
// its lookup holds until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module pes_header_stream_sorter #(
  parameter int PID_COUNT    = phss_pkg::PID_COUNT_DEF,
  parameter int NUMBER_WIDTH = phss_pkg::NUMBER_WIDTH_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // pid[12:0], payload_size[20:13], start_code[44:21], stream_id[52:45],
  // flag_byte[60:53], header_length[68:61], zero[71:69]
  input  wire [phss_pkg::IN_DATA_W-1:0]        s_axis_tdata_i,
  // new_packet[0]
  input  wire [0:0]                            s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire                                  m_axis_tready_i,
  // es_number[7:0], data_offset[15:8], data_size[23:16]
  output logic [phss_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  // es_type[0]
  output logic [0:0]                           m_axis_tuser_o
);

  phss_pkg::ctrl_cmd_t cmd;
  phss_pkg::ctrl_sts_t sts;

  logic                        es_type;
  logic [phss_pkg::BYTE_W-1:0] es_number;
  logic [phss_pkg::BYTE_W-1:0] data_offset;
  logic [phss_pkg::BYTE_W-1:0] data_size;

  phss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  phss_dp #(
    .PID_COUNT    (PID_COUNT),
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .pid_i           (s_axis_tdata_i[12:0]),
    .new_packet_i    (s_axis_tuser_i[0]),
    .payload_size_i  (s_axis_tdata_i[20:13]),
    .start_code_i    (s_axis_tdata_i[44:21]),
    .stream_id_i     (s_axis_tdata_i[52:45]),
    .flag_byte_i     (s_axis_tdata_i[60:53]),
    .header_length_i (s_axis_tdata_i[68:61]),
    .out_ready_i     (m_axis_tready_i),
    .out_valid_o     (m_axis_tvalid_o),
    .es_type_o       (es_type),
    .es_number_o     (es_number),
    .data_offset_o   (data_offset),
    .data_size_o     (data_size)
  );

  // Pack the result transfer.
  assign m_axis_tdata_o = {data_size, data_offset, es_number};
  assign m_axis_tuser_o = es_type;

  // No descriptor is taken during the clearing pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_en |-> !s_axis_tready_o)
    else $error("descriptor accepted during table clearing");

  // A capture is always followed by a lookup cycle, never by another capture.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> !cmd.capture)
    else $error("two captures in consecutive cycles");

  // A lookup never commits while the previous result is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !cmd.commit)
    else $error("commit over a stalled result");

  // Table writes from the clearing pass and from a commit never meet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.clr_en && (cmd.commit || cmd.capture)))
    else $error("clearing pass overlaps item processing");

endmodule

`default_nettype wire

// File: rtl/phss_dp.sv
// Datapath: PID table memory, stream counters, header decode and output register.
`timescale 1ns / 1ps
`default_nettype none

module phss_dp #(
  parameter int PID_COUNT    = phss_pkg::PID_COUNT_DEF,
  parameter int NUMBER_WIDTH = phss_pkg::NUMBER_WIDTH_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire phss_pkg::ctrl_cmd_t        cmd_i,
  output phss_pkg::ctrl_sts_t             sts_o,
  input  wire [phss_pkg::PID_W-1:0]       pid_i,
  input  wire                             new_packet_i,
  input  wire [phss_pkg::BYTE_W-1:0]      payload_size_i,
  input  wire [phss_pkg::CODE_W-1:0]      start_code_i,
  input  wire [phss_pkg::BYTE_W-1:0]      stream_id_i,
  input  wire [phss_pkg::BYTE_W-1:0]      flag_byte_i,
  input  wire [phss_pkg::BYTE_W-1:0]      header_length_i,
  input  wire                             out_ready_i,
  output logic                            out_valid_o,
  output logic                            es_type_o,
  output logic [phss_pkg::BYTE_W-1:0]     es_number_o,
  output logic [phss_pkg::BYTE_W-1:0]     data_offset_o,
  output logic [phss_pkg::BYTE_W-1:0]     data_size_o
);

  localparam int AW = $clog2(PID_COUNT);
  localparam int EW = NUMBER_WIDTH + 3;
  localparam int PID_CMP_W = phss_pkg::PID_W + 1;

  // Table entry: known bit on top, then the kind, then the stream number.
  logic [EW-1:0] mem [PID_COUNT];
  logic [EW-1:0] rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;

  logic [AW-1:0] clr_addr_q, clr_addr_d;

  // Captured descriptor.
  logic [phss_pkg::PID_W-1:0]  pid_q;
  logic                        newp_q;
  logic [phss_pkg::BYTE_W-1:0] size_q;
  logic [phss_pkg::CODE_W-1:0] code_q;
  logic [phss_pkg::BYTE_W-1:0] sid_q;
  logic [phss_pkg::BYTE_W-1:0] flags_q;
  logic [phss_pkg::BYTE_W-1:0] hlen_q;
  logic                        in_range_q;

  logic [NUMBER_WIDTH-1:0] audio_q, audio_d;
  logic [NUMBER_WIDTH-1:0] video_q, video_d;
  logic [NUMBER_WIDTH-1:0] audio_inc, video_inc;

  logic                    hdr;
  logic                    known;
  logic                    fresh;
  logic                    fail;
  logic                    result;
  logic [8:0]              off9;
  phss_pkg::es_kind_e      ent_kind, new_kind, eff_kind;
  logic [NUMBER_WIDTH-1:0] ent_num, new_num, eff_num;
  logic [NUMBER_WIDTH+7:0] num_wide;

  logic                        out_valid_q, out_valid_d;
  logic                        type_q;
  logic [phss_pkg::BYTE_W-1:0] num_q, off_q, dsize_q;

  // Clearing pass address.
  assign clr_addr_d = cmd_i.clr_en ? clr_addr_q + AW'(1) : clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else begin
      clr_addr_q <= clr_addr_d;
    end
  end

  // Descriptor capture and table read on an accepted transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pid_q      <= pid_i;
      newp_q     <= new_packet_i;
      size_q     <= payload_size_i;
      code_q     <= start_code_i;
      sid_q      <= stream_id_i;
      flags_q    <= flag_byte_i;
      hlen_q     <= header_length_i;
      in_range_q <= ({1'b0, pid_i} < PID_CMP_W'(PID_COUNT));
      rdata_q    <= mem[pid_i[AW-1:0]];
    end
  end

  // Table write port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Header decode on the captured descriptor.
  always_comb begin
    hdr = newp_q && (size_q >= phss_pkg::HDR_MIN) && (code_q == phss_pkg::START_CODE);
    known    = rdata_q[EW-1];
    ent_kind = phss_pkg::es_kind_e'(rdata_q[EW-2:EW-3]);
    ent_num  = rdata_q[NUMBER_WIDTH-1:0];
    fresh    = in_range_q && hdr && !known;
  end

  // Saturating counters and the kind of a newly seen stream.
  assign audio_inc = (audio_q == '1) ? audio_q : audio_q + NUMBER_WIDTH'(1);
  assign video_inc = (video_q == '1) ? video_q : video_q + NUMBER_WIDTH'(1);

  always_comb begin
    if (sid_q >= phss_pkg::SID_AUDIO_LO && sid_q <= phss_pkg::SID_AUDIO_HI) begin
      new_kind = phss_pkg::KIND_AUDIO;
      new_num  = audio_inc;
    end else if (sid_q >= phss_pkg::SID_VIDEO_LO && sid_q <= phss_pkg::SID_VIDEO_HI) begin
      new_kind = phss_pkg::KIND_VIDEO;
      new_num  = video_inc;
    end else begin
      new_kind = phss_pkg::KIND_OTHER;
      new_num  = '0;
    end
    eff_kind = fresh ? new_kind : ent_kind;
    eff_num  = fresh ? new_num : ent_num;
  end

  // Offset of the elementary-stream data and the failing cases.
  always_comb begin
    fail = 1'b0;
    off9 = '0;
    if (hdr) begin
      if (size_q < phss_pkg::SHORT_LIMIT) begin
        off9 = {1'b0, size_q};
      end else if (flags_q[7:6] != phss_pkg::OPT_MARK) begin
        off9 = {1'b0, phss_pkg::HDR_MIN};
      end else if (size_q < phss_pkg::OPT_MIN_SIZE) begin
        fail = 1'b1;
      end else begin
        off9 = {1'b0, phss_pkg::OPT_MIN_SIZE} + {1'b0, hlen_q};
        fail = off9 > {1'b0, size_q};
      end
    end
    result = in_range_q && (hdr || known) && !fail && (eff_kind != phss_pkg::KIND_OTHER);
  end

  // Write mux: clearing pass or registration of a new PID.
  always_comb begin
    if (cmd_i.clr_en) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = cmd_i.commit && fresh;
      mem_waddr = pid_q[AW-1:0];
      mem_wdata = {1'b1, new_kind, new_num};
    end
  end

  // Counter update when a new audio or video stream registers.
  always_comb begin
    audio_d = audio_q;
    video_d = video_q;
    if (cmd_i.commit && fresh) begin
      if (new_kind == phss_pkg::KIND_AUDIO) begin
        audio_d = audio_inc;
      end
      if (new_kind == phss_pkg::KIND_VIDEO) begin
        video_d = video_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      audio_q <= '0;
      video_q <= '0;
    end else begin
      audio_q <= audio_d;
      video_q <= video_d;
    end
  end

  // Output register.
  assign num_wide = {8'd0, eff_num};

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit && result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && result) begin
      type_q  <= (eff_kind == phss_pkg::KIND_VIDEO);
      num_q   <= num_wide[7:0];
      off_q   <= off9[7:0];
      dsize_q <= size_q - off9[7:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign es_type_o     = type_q;
  assign es_number_o   = num_q;
  assign data_offset_o = off_q;
  assign data_size_o   = dsize_q;

  assign sts_o.clr_last = (clr_addr_q == AW'(PID_COUNT - 1));
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

endmodule

`default_nettype wire

// File: rtl/phss_ctrl.sv
// Controller: sequences the table clearing pass, descriptor capture and lookup.
`timescale 1ns / 1ps
`default_nettype none

module phss_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire phss_pkg::ctrl_sts_t sts_i,
  output phss_pkg::ctrl_cmd_t  cmd_o
);

  phss_pkg::state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      phss_pkg::ST_CLEAR: begin
        if (sts_i.clr_last) begin
          state_d = phss_pkg::ST_IDLE;
        end
      end
      phss_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = phss_pkg::ST_LOOKUP;
        end
      end
      phss_pkg::ST_LOOKUP: begin
        if (!sts_i.out_busy) begin
          state_d = phss_pkg::ST_IDLE;
        end
      end
      default: state_d = phss_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= phss_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Outputs.
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.clr_en  = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      phss_pkg::ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
      end
      phss_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      phss_pkg::ST_LOOKUP: begin
        cmd_o.commit = !sts_i.out_busy;
      end
      default: begin
        cmd_o.clr_en = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire
